// ----- rtl/doubly_linked_list_engine_macros.svh -----
`ifndef DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define DLLE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define DLLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/dlle_pkg.sv -----
package dlle_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int ACTION_W     = 3;
    localparam int STATUS_W     = 2;

    typedef struct packed {
        logic node_we;
        logic clr_en;
        logic next_we;
        logic prev_we;
    } cell_cmd_t;

endpackage

// ----- rtl/dlle_cell.sv -----
module dlle_cell #(
    parameter int CAPACITY = dlle_pkg::CAPACITY_DEF,
    parameter int ID       = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dlle_pkg::cell_cmd_t                    cmd,
    input  logic [$clog2(CAPACITY+1)-1:0]          node_idx,
    input  logic signed [dlle_pkg::VALUE_W-1:0]    node_value,
    input  logic [$clog2(CAPACITY+1)-1:0]          node_next,
    input  logic [$clog2(CAPACITY+1)-1:0]          node_prev,
    input  logic [$clog2(CAPACITY+1)-1:0]          clr_idx,
    input  logic [$clog2(CAPACITY+1)-1:0]          nxt_idx,
    input  logic [$clog2(CAPACITY+1)-1:0]          nxt_link,
    input  logic [$clog2(CAPACITY+1)-1:0]          prv_idx,
    input  logic [$clog2(CAPACITY+1)-1:0]          prv_link,
    input  logic [$clog2(CAPACITY+1)-1:0]          rd_idx,
    input  logic signed [dlle_pkg::VALUE_W-1:0]    rd_value_in,
    input  logic [$clog2(CAPACITY+1)-1:0]          rd_next_in,
    input  logic [$clog2(CAPACITY+1)-1:0]          rd_prev_in,
    output logic signed [dlle_pkg::VALUE_W-1:0]    rd_value_out,
    output logic [$clog2(CAPACITY+1)-1:0]          rd_next_out,
    output logic [$clog2(CAPACITY+1)-1:0]          rd_prev_out,
    input  logic [$clog2(CAPACITY+1)-1:0]          free_in,
    output logic [$clog2(CAPACITY+1)-1:0]          free_out,
    output logic                                   in_use
);
    import dlle_pkg::*;

    localparam int              IDX_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] NIL   = IDX_W'(CAPACITY);
    localparam logic [IDX_W-1:0] MY_ID = IDX_W'(ID);

    logic signed [VALUE_W-1:0] value_reg;
    logic [IDX_W-1:0]          next_reg;
    logic [IDX_W-1:0]          prev_reg;
    logic                      use_reg;

    logic node_hit;
    logic clr_hit;
    logic next_hit;
    logic prev_hit;

    assign node_hit = cmd.node_we && (node_idx == MY_ID);
    assign clr_hit  = cmd.clr_en  && (clr_idx  == MY_ID);
    assign next_hit = cmd.next_we && (nxt_idx  == MY_ID);
    assign prev_hit = cmd.prev_we && (prv_idx  == MY_ID);

    always_ff @(posedge clk)
    begin
        if (node_hit)
        begin
            value_reg <= node_value;
        end
        if (next_hit)
        begin
            next_reg <= nxt_link;
        end
        else if (node_hit)
        begin
            next_reg <= node_next;
        end
        if (prev_hit)
        begin
            prev_reg <= prv_link;
        end
        else if (node_hit)
        begin
            prev_reg <= node_prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg <= 1'b0;
        end
        else if (node_hit)
        begin
            use_reg <= 1'b1;
        end
        else if (clr_hit)
        begin
            use_reg <= 1'b0;
        end
    end

    // Pass the addressed node down the row, or forward what came in.
    assign rd_value_out = (rd_idx == MY_ID) ? value_reg : rd_value_in;
    assign rd_next_out  = (rd_idx == MY_ID) ? next_reg  : rd_next_in;
    assign rd_prev_out  = (rd_idx == MY_ID) ? prev_reg  : rd_prev_in;

    // Keep the lowest free slot found so far, else offer this one.
    assign free_out = (free_in != NIL) ? free_in : (use_reg ? NIL : MY_ID);
    assign in_use   = use_reg;

endmodule

// ----- rtl/doubly_linked_list_engine.sv -----
// An insert passes S_INSERT then S_FINISH; a delete steps node by node in S_DELETE to a hit
// or the list end, then S_FINISH; a walk emits its nodes from S_WALK; an empty delete or walk
// goes to S_FINISH. New items are taken only in S_IDLE, so each finishes before the next; the
// pointer follows one link per cycle, in a walk only while the output register is free.
// Reset (asynchronous, active low) empties the list: all slots free, head and tail null,
// count zero, no result pending.
`include "doubly_linked_list_engine_macros.svh"

module doubly_linked_list_engine #(
    parameter int CAPACITY = dlle_pkg::CAPACITY_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic signed [dlle_pkg::VALUE_W-1:0]   s_axis_tdata,   // value
    input  logic [dlle_pkg::ACTION_W-1:0]         s_axis_tuser,   // action
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic signed [dlle_pkg::VALUE_W-1:0]   m_axis_tdata,   // item_value
    output logic [dlle_pkg::STATUS_W-1:0]         m_axis_tuser,   // status
    output logic                                  m_axis_tlast    // last
);
    import dlle_pkg::*;

    localparam int               IDX_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] NIL   = IDX_W'(CAPACITY);

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_TAIL = 3'd1,
        ACT_DELETE   = 3'd2,
        ACT_WALK_FWD = 3'd3,
        ACT_WALK_BWD = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_DELETE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t                    state_reg,      state_next;
    logic                      dir_reg,        dir_next;
    logic signed [VALUE_W-1:0] value_reg,      value_next;
    logic [IDX_W-1:0]          cur_reg,        cur_next;
    status_t                   status_reg,     status_next;
    logic [IDX_W-1:0]          head_reg,       head_next;
    logic [IDX_W-1:0]          tail_reg,       tail_next;
    logic [IDX_W-1:0]          count_reg,      count_next;
    logic                      out_valid_reg,  out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg,  out_value_next;
    status_t                   out_status_reg, out_status_next;
    logic                      out_last_reg,   out_last_next;

    cell_cmd_t                 cmd;
    logic [IDX_W-1:0]          node_idx;
    logic signed [VALUE_W-1:0] node_value;
    logic [IDX_W-1:0]          node_next;
    logic [IDX_W-1:0]          node_prev;
    logic [IDX_W-1:0]          nxt_idx;
    logic [IDX_W-1:0]          nxt_link;
    logic [IDX_W-1:0]          prv_idx;
    logic [IDX_W-1:0]          prv_link;

    logic signed [VALUE_W-1:0] rd_value_c [CAPACITY+1];
    logic [IDX_W-1:0]          rd_next_c  [CAPACITY+1];
    logic [IDX_W-1:0]          rd_prev_c  [CAPACITY+1];
    logic [IDX_W-1:0]          free_c     [CAPACITY+1];
    logic [CAPACITY-1:0]       in_use_vec;

    logic signed [VALUE_W-1:0] rd_value;
    logic [IDX_W-1:0]          rd_next;
    logic [IDX_W-1:0]          rd_prev;
    logic [IDX_W-1:0]          free_slot;
    logic [IDX_W-1:0]          walk_next;
    logic                      head_ok;
    logic                      tail_ok;
    logic                      cur_ok;
    logic                      out_free;
    logic                      in_fire;

    assign rd_value_c[0] = '0;
    assign rd_next_c[0]  = NIL;
    assign rd_prev_c[0]  = NIL;
    assign free_c[0]     = NIL;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        dlle_cell #(
            .CAPACITY (CAPACITY),
            .ID       (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .node_idx     (node_idx),
            .node_value   (node_value),
            .node_next    (node_next),
            .node_prev    (node_prev),
            .clr_idx      (cur_reg),
            .nxt_idx      (nxt_idx),
            .nxt_link     (nxt_link),
            .prv_idx      (prv_idx),
            .prv_link     (prv_link),
            .rd_idx       (cur_reg),
            .rd_value_in  (rd_value_c[i]),
            .rd_next_in   (rd_next_c[i]),
            .rd_prev_in   (rd_prev_c[i]),
            .rd_value_out (rd_value_c[i+1]),
            .rd_next_out  (rd_next_c[i+1]),
            .rd_prev_out  (rd_prev_c[i+1]),
            .free_in      (free_c[i]),
            .free_out     (free_c[i+1]),
            .in_use       (in_use_vec[i])
        );
    end

    assign rd_value  = rd_value_c[CAPACITY];
    assign rd_next   = rd_next_c[CAPACITY];
    assign rd_prev   = rd_prev_c[CAPACITY];
    assign free_slot = free_c[CAPACITY];
    assign walk_next = dir_reg ? rd_next : rd_prev;

    assign head_ok  = head_reg < NIL;
    assign tail_ok  = tail_reg < NIL;
    assign cur_ok   = cur_reg < NIL;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        dir_next        = dir_reg;
        value_next      = value_reg;
        cur_next        = cur_reg;
        status_next     = status_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        cmd        = '0;
        node_idx   = free_slot;
        node_value = value_reg;
        node_next  = NIL;
        node_prev  = NIL;
        nxt_idx    = '0;
        nxt_link   = NIL;
        prv_idx    = '0;
        prv_link   = NIL;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    value_next = s_axis_tdata;
                    unique case (s_axis_tuser) inside
                        ACT_INS_HEAD,
                        ACT_INS_TAIL:
                        begin
                            dir_next   = (s_axis_tuser == ACT_INS_HEAD);
                            state_next = S_INSERT;
                        end
                        ACT_DELETE:
                        begin
                            cur_next = head_reg;
                            if (head_ok)
                            begin
                                state_next = S_DELETE;
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FINISH;
                            end
                        end
                        ACT_WALK_FWD:
                        begin
                            dir_next = 1'b1;
                            cur_next = head_reg;
                            if (head_ok)
                            begin
                                state_next = S_WALK;
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FINISH;
                            end
                        end
                        ACT_WALK_BWD:
                        begin
                            dir_next = 1'b0;
                            cur_next = tail_reg;
                            if (tail_ok)
                            begin
                                state_next = S_WALK;
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                state_next = S_FINISH;
                if (count_reg == NIL)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next  = ST_OK;
                    cmd.node_we  = 1'b1;
                    count_next   = count_reg + 1'b1;
                    if (!head_ok || !tail_ok)
                    begin
                        head_next = free_slot;
                        tail_next = free_slot;
                    end
                    else if (dir_reg)
                    begin
                        node_next   = head_reg;
                        cmd.prev_we = 1'b1;
                        prv_idx     = head_reg;
                        prv_link    = free_slot;
                        head_next   = free_slot;
                    end
                    else
                    begin
                        node_prev   = tail_reg;
                        cmd.next_we = 1'b1;
                        nxt_idx     = tail_reg;
                        nxt_link    = free_slot;
                        tail_next   = free_slot;
                    end
                end
            end
            S_DELETE:
            begin
                if (!cur_ok)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
                else if (rd_value == value_reg)
                begin
                    // Unlink the node and free its slot.
                    cmd.clr_en = 1'b1;
                    if (rd_prev < NIL)
                    begin
                        cmd.next_we = 1'b1;
                        nxt_idx     = rd_prev;
                        nxt_link    = rd_next;
                    end
                    else
                    begin
                        head_next = rd_next;
                    end
                    if (rd_next < NIL)
                    begin
                        cmd.prev_we = 1'b1;
                        prv_idx     = rd_next;
                        prv_link    = rd_prev;
                    end
                    else
                    begin
                        tail_next = rd_prev;
                    end
                    count_next  = count_reg - 1'b1;
                    status_next = ST_OK;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cur_next = rd_next;
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_value;
                    out_status_next = ST_OK;
                    out_last_next   = !(walk_next < NIL);
                    cur_next        = walk_next;
                    if (!(walk_next < NIL))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dir_reg        <= 1'b0;
            value_reg      <= '0;
            cur_reg        <= NIL;
            status_reg     <= ST_OK;
            head_reg       <= NIL;
            tail_reg       <= NIL;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dir_reg        <= dir_next;
            value_reg      <= value_next;
            cur_reg        <= cur_next;
            status_reg     <= status_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    `DLLE_ASSERT_ALWAYS(a_count_matches_slots, clk, rst_n, count_reg == $countones(in_use_vec), "node count disagrees with occupied slots")
    `DLLE_ASSERT_ALWAYS(a_head_tail_null, clk, rst_n, head_ok == tail_ok, "head and tail disagree on empty list")
    `DLLE_ASSERT_ALWAYS(a_empty_count, clk, rst_n, (count_reg == '0) == !head_ok, "empty list with nonzero count")
    `DLLE_ASSERT_IMPLY(a_walk_valid_node, clk, rst_n, state_reg == S_WALK, cur_ok, "walk on null node")

endmodule
